/* src/lbfb_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the LED bar frame builder.
// No dependencies; every other file in src imports this package.
package lbfb_pkg;

  localparam int SEGMENT_COUNT = 10;
  localparam int FRAME_WORDS   = SEGMENT_COUNT + 3;
  localparam int SEG_IDX_W     = $clog2(SEGMENT_COUNT);
  localparam int WORD_IDX_W    = $clog2(FRAME_WORDS);

  localparam logic [WORD_IDX_W-1:0] LAST_WORD_IDX = WORD_IDX_W'(FRAME_WORDS - 1);
  localparam logic [6:0]            MAX_LEVEL     = 7'(8 * SEGMENT_COUNT);
  localparam logic [7:0]            MASK_FULL     = 8'hFF;
  localparam logic [7:0]            MASK_OFF      = 8'h00;

  // Update modes; codes above MODE_REFRESH behave as refresh
  localparam logic [2:0] MODE_BAR     = 3'd0;
  localparam logic [2:0] MODE_SET     = 3'd1;
  localparam logic [2:0] MODE_TOGGLE  = 3'd2;
  localparam logic [2:0] MODE_PATTERN = 3'd3;
  localparam logic [2:0] MODE_REFRESH = 3'd4;

  // Configuration register indexes
  localparam logic CFG_REVERSE_ORDER = 1'b0;
  localparam logic CFG_COMMAND_WORD  = 1'b1;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] level_eighths;
    logic [3:0] led_number;
    logic [3:0] brightness_eighths;
    logic [9:0] bit_pattern;
  } in_item_t;

  typedef struct packed {
    logic [15:0] frame_word;
    logic        last_word;
    logic [9:0]  lit_mask;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                  load_item;
    logic                  apply_update;
    logic                  emit;
    logic [WORD_IDX_W-1:0] word_idx;
  } lbfb_cmd_t;

  // Thermometer code: n low bits set, saturating at a full mask
  function automatic logic [7:0] thermo(input logic [6:0] eighths);
    logic [7:0] m;
    if (eighths >= 7'd8) begin
      m = MASK_FULL;
    end else begin
      m = 8'((9'd1 << eighths[2:0]) - 9'd1);
    end
    return m;
  endfunction

endpackage

/* src/lbfb_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the LED bar frame builder: sequences update and frame words.
// Depends on lbfb_pkg.
module lbfb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output lbfb_pkg::lbfb_cmd_t cmd
);
  import lbfb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SEND
  } state_t;

  state_t                state_r, state_nxt;
  logic [WORD_IDX_W-1:0] word_idx_r, word_idx_nxt;

  always_comb begin
    state_nxt    = state_r;
    word_idx_nxt = word_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt    = ST_SEND;
        word_idx_nxt = '0;
      end
      ST_SEND: begin
        if (word_idx_r == LAST_WORD_IDX) begin
          state_nxt = ST_IDLE;
        end else begin
          word_idx_nxt = word_idx_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      word_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      word_idx_r <= word_idx_nxt;
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign cmd.load_item    = (state_r == ST_IDLE) && start;
  assign cmd.apply_update = (state_r == ST_UPDATE);
  assign cmd.emit         = (state_r == ST_SEND);
  assign cmd.word_idx     = word_idx_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> busy && !cmd.load_item)
    else $error("word emitted while idle");

  a_last_word_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.word_idx == LAST_WORD_IDX |=> !busy)
    else $error("frame did not end after its last word");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> cmd.word_idx <= LAST_WORD_IDX)
    else $error("word index beyond frame");

endmodule

/* src/lbfb_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the LED bar frame builder: segment masks, config registers,
// mask update and frame word output register. Depends on lbfb_pkg.
module lbfb_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lbfb_pkg::in_item_t   in_data,
  input  lbfb_pkg::lbfb_cmd_t  cmd,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_wdata,
  output logic                 out_valid,
  output lbfb_pkg::out_item_t  out_data
);
  import lbfb_pkg::*;

  in_item_t    item_r;
  logic [7:0]  masks_r   [SEGMENT_COUNT];
  logic [7:0]  masks_nxt [SEGMENT_COUNT];
  logic        reverse_r;
  logic [15:0] command_r;
  logic        out_valid_r;
  out_item_t   out_data_r, out_data_nxt;

  logic [6:0]           level;
  logic [3:0]           led_clamped;
  logic [SEG_IDX_W-1:0] led_idx;
  logic [9:0]           lit;
  logic [SEG_IDX_W-1:0] seg_sel;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_r <= 1'b0;
      command_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REVERSE_ORDER: reverse_r <= cfg_wdata[0];
        CFG_COMMAND_WORD:  command_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp level to the bar length and led number to 1..SEGMENT_COUNT
  always_comb begin
    level = (item_r.level_eighths > MAX_LEVEL) ? MAX_LEVEL : item_r.level_eighths;
    led_clamped = item_r.led_number;
    if (led_clamped < 4'd1) begin
      led_clamped = 4'd1;
    end
    if (led_clamped > 4'(SEGMENT_COUNT)) begin
      led_clamped = 4'(SEGMENT_COUNT);
    end
    led_idx = SEG_IDX_W'(led_clamped - 4'd1);
  end

  // Every segment works out its own next mask
  always_comb begin
    for (int i = 0; i < SEGMENT_COUNT; i++) begin
      masks_nxt[i] = masks_r[i];
      case (item_r.mode)
        MODE_BAR: begin
          if (level > 7'(8 * i)) begin
            masks_nxt[i] = thermo(level - 7'(8 * i));
          end else begin
            masks_nxt[i] = MASK_OFF;
          end
        end
        MODE_SET: begin
          if (led_idx == SEG_IDX_W'(i)) begin
            masks_nxt[i] = thermo({3'd0, item_r.brightness_eighths});
          end
        end
        MODE_TOGGLE: begin
          if (led_idx == SEG_IDX_W'(i)) begin
            masks_nxt[i] = (masks_r[i] != MASK_OFF) ? MASK_OFF : MASK_FULL;
          end
        end
        MODE_PATTERN: begin
          masks_nxt[i] = item_r.bit_pattern[i] ? MASK_FULL : MASK_OFF;
        end
        default: ; // refresh and unused codes hold the masks
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SEGMENT_COUNT; i++) begin
        masks_r[i] <= MASK_OFF;
      end
    end else if (cmd.apply_update) begin
      for (int i = 0; i < SEGMENT_COUNT; i++) begin
        masks_r[i] <= masks_nxt[i];
      end
    end
  end

  always_comb begin
    lit = '0;
    for (int i = 0; i < SEGMENT_COUNT; i++) begin
      lit[i] = (masks_r[i] != MASK_OFF);
    end
  end

  // Word 0 is the command, then one word per segment, then zero pads
  always_comb begin
    seg_sel = reverse_r ? SEG_IDX_W'(4'(SEGMENT_COUNT) - 4'(cmd.word_idx))
                        : SEG_IDX_W'(4'(cmd.word_idx) - 4'd1);
    out_data_nxt.frame_word = 16'd0;
    if (cmd.word_idx == '0) begin
      out_data_nxt.frame_word = command_r;
    end else if (cmd.word_idx <= WORD_IDX_W'(SEGMENT_COUNT)) begin
      out_data_nxt.frame_word = {8'd0, masks_r[seg_sel]};
    end
    out_data_nxt.last_word = (cmd.word_idx == LAST_WORD_IDX);
    out_data_nxt.lit_mask  = lit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_valid_follows_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("emitted word did not reach the output");

  a_masks_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> lit == $past(lit))
    else $error("masks changed during a frame");

  a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_word |=> !out_valid)
    else $error("word after the last word of a frame");

endmodule

/* src/led_bar_frame_builder_unit.sv */
`timescale 1ns / 1ps
// Top level of the LED bar frame builder: controller plus datapath.
// Depends on lbfb_pkg, lbfb_ctrl and lbfb_datapath.
//
// Each accepted item (start high while busy is low) first updates the ten
// segment masks in the update state, then sends a 13-word frame, one word per
// cycle with out_valid high: the command word, the ten segment words (reversed
// when reverse_order is set) and two zero pads, the last one flagged by
// last_word. The first word is on the outputs once the update state has passed
// and the first send state's word has been registered. busy stays high through
// the update state and the whole word sequence, and the next item is taken only
// once busy is low again, so no item is accepted while a frame is sent. The receiver cannot
// stall: each word is shown for exactly one cycle. Write configuration only
// while busy is low and no frame word is still pending.
module led_bar_frame_builder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lbfb_pkg::in_item_t  in_data,
  output logic                out_valid,
  output lbfb_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import lbfb_pkg::*;

  lbfb_cmd_t cmd;

  lbfb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  lbfb_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* bench/led_bar_frame_builder_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for led_bar_frame_builder_unit: predicts every 13-word frame
// from its own copy of the segment masks and registers. Depends on lbfb_pkg and the RTL.
module led_bar_frame_builder_unit_test;
  import lbfb_pkg::*;

  localparam int         HALF_PERIOD   = 4;
  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         SETTLE_CYCLES = 24;
  localparam int         IDLE_PERCENT  = 14;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  in_item_t    in_data   = '0;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = CFG_REVERSE_ORDER;
  logic [15:0] cfg_wdata = '0;

  // Predictor state, mirrors what the unit should hold
  logic [7:0]  seg_model [SEGMENT_COUNT];
  logic        reverse_model = 1'b0;
  logic [15:0] command_model = '0;

  in_item_t    pending_items[$];
  out_item_t   expected_words[$];
  int          idle_percent   = IDLE_PERCENT;
  int          items_accepted = 0;
  int          words_checked  = 0;
  int          mismatch_count = 0;
  int          cycle_count    = 0;

  led_bar_frame_builder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [7:0] brightness_mask(input int unsigned eighths);
    logic [7:0] m;
    if (eighths >= 8) begin
      m = MASK_FULL;
    end else begin
      m = 8'((1 << eighths) - 1);
    end
    return m;
  endfunction

  // Out-of-range led numbers land on the nearest end of the bar
  function automatic int unsigned led_slot(input logic [3:0] number);
    int unsigned n;
    n = number;
    if (n < 1) n = 1;
    if (n > SEGMENT_COUNT) n = SEGMENT_COUNT;
    return n - 1;
  endfunction

  task automatic predict_frame(input in_item_t it);
    int unsigned level;
    int unsigned rest;
    int unsigned slot;
    logic [9:0]  lit;
    out_item_t   w;
    case (it.mode)
      MODE_BAR: begin
        level = it.level_eighths;
        if (level > 8 * SEGMENT_COUNT) level = 8 * SEGMENT_COUNT;
        for (int i = 0; i < SEGMENT_COUNT; i++) begin
          rest = (level > 8 * i) ? level - 8 * i : 0;
          seg_model[i] = brightness_mask(rest);
        end
      end
      MODE_SET: begin
        seg_model[led_slot(it.led_number)] = brightness_mask(it.brightness_eighths);
      end
      MODE_TOGGLE: begin
        slot = led_slot(it.led_number);
        seg_model[slot] = (seg_model[slot] != MASK_OFF) ? MASK_OFF : MASK_FULL;
      end
      MODE_PATTERN: begin
        for (int i = 0; i < SEGMENT_COUNT; i++)
          seg_model[i] = it.bit_pattern[i] ? MASK_FULL : MASK_OFF;
      end
      default: begin
        // refresh and spare codes keep the masks
      end
    endcase
    lit = '0;
    for (int i = 0; i < SEGMENT_COUNT; i++)
      lit[i] = (seg_model[i] != MASK_OFF);
    for (int k = 0; k < FRAME_WORDS; k++) begin
      if (k == 0) begin
        w.frame_word = command_model;
      end else if (k <= SEGMENT_COUNT) begin
        w.frame_word = {8'h00, seg_model[reverse_model ? SEGMENT_COUNT - k : k - 1]};
      end else begin
        w.frame_word = '0;
      end
      w.last_word = (k == FRAME_WORDS - 1);
      w.lit_mask  = lit;
      expected_words.push_back(w);
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // Driver: hold start until the item is taken, then pick the next one or idle
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_frame(in_data);
        items_accepted++;
      end
      if (!start || !busy) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_percent) begin
          in_data <= pending_items.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_words
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        report_mismatch("frame word with nothing outstanding", 0, out_data.frame_word);
      end else begin
        want = expected_words.pop_front();
        if (out_data.frame_word !== want.frame_word)
          report_mismatch("frame_word", want.frame_word, out_data.frame_word);
        if (out_data.last_word !== want.last_word)
          report_mismatch("last_word", want.last_word, out_data.last_word);
        if (out_data.lit_mask !== want.lit_mask)
          report_mismatch("lit_mask", want.lit_mask, out_data.lit_mask);
        words_checked++;
      end
    end
  end

  task automatic write_reg(input logic index, input logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == CFG_REVERSE_ORDER) begin
      reverse_model = value[0];
    end else begin
      command_model = value;
    end
  endtask

  // Sample at the falling edge so the driver and checker have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || start || expected_words.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic in_item_t shaped(input logic [2:0] mode, input int unsigned level,
                                      input int unsigned led, input int unsigned bright,
                                      input int unsigned pattern);
    in_item_t it;
    it.mode               = mode;
    it.level_eighths      = 7'(level);
    it.led_number         = 4'(led);
    it.brightness_eighths = 4'(bright);
    it.bit_pattern        = 10'(pattern);
    return it;
  endfunction

  // Mostly the four updating modes, level and brightness mostly in range, some refresh and spare codes
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    it = shaped(MODE_BAR, $urandom_range(127), $urandom_range(15), $urandom_range(15),
                $urandom_range(1023));
    pick = $urandom_range(99);
    if (pick < 25) begin
      it.mode = MODE_BAR;
      if ($urandom_range(3) != 0) it.level_eighths = 7'($urandom_range(8 * SEGMENT_COUNT));
    end else if (pick < 45) begin
      it.mode = MODE_SET;
      if ($urandom_range(3) != 0) it.brightness_eighths = 4'($urandom_range(8));
    end else if (pick < 65) begin
      it.mode = MODE_TOGGLE;
    end else if (pick < 85) begin
      it.mode = MODE_PATTERN;
    end else if (pick < 92) begin
      it.mode = MODE_REFRESH;
    end else begin
      it.mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
    end
    return it;
  endfunction

  task automatic random_phase(input logic reverse, input logic [15:0] command,
                              input int count, input int idle);
    write_reg(CFG_REVERSE_ORDER, {15'd0, reverse});
    write_reg(CFG_COMMAND_WORD, command);
    idle_percent = idle;
    repeat (count) pending_items.push_back(random_item());
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < SEGMENT_COUNT; i++) seg_model[i] = MASK_OFF;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_REVERSE_ORDER, 16'd0);
    write_reg(CFG_COMMAND_WORD, 16'h8000);
    // Refresh straight after reset shows the all-dark bar
    pending_items.push_back(shaped(MODE_REFRESH, 0, 0, 0, 0));
    foreach (pending_items[i]) ;
    pending_items.push_back(shaped(MODE_BAR, 0, 15, 15, 1023));
    pending_items.push_back(shaped(MODE_BAR, 1, 0, 0, 0));
    pending_items.push_back(shaped(MODE_BAR, 7, 0, 0, 0));
    pending_items.push_back(shaped(MODE_BAR, 8, 0, 0, 0));
    pending_items.push_back(shaped(MODE_BAR, 9, 0, 0, 0));
    pending_items.push_back(shaped(MODE_BAR, 43, 0, 0, 0));
    pending_items.push_back(shaped(MODE_BAR, 80, 0, 0, 0));
    pending_items.push_back(shaped(MODE_BAR, 127, 0, 0, 0));
    pending_items.push_back(shaped(MODE_BAR, 0, 0, 0, 0));
    // Set with clamped led numbers and brightness above full
    pending_items.push_back(shaped(MODE_SET, 127, 0, 8, 0));
    pending_items.push_back(shaped(MODE_SET, 0, 10, 3, 0));
    pending_items.push_back(shaped(MODE_SET, 0, 15, 15, 1023));
    pending_items.push_back(shaped(MODE_SET, 0, 5, 0, 0));
    pending_items.push_back(shaped(MODE_SET, 0, 5, 1, 0));
    // Toggle a dark led on and off, then a lit one
    pending_items.push_back(shaped(MODE_TOGGLE, 0, 3, 0, 0));
    pending_items.push_back(shaped(MODE_TOGGLE, 0, 3, 0, 0));
    pending_items.push_back(shaped(MODE_TOGGLE, 0, 0, 0, 0));
    pending_items.push_back(shaped(MODE_TOGGLE, 0, 5, 0, 0));
    pending_items.push_back(shaped(MODE_PATTERN, 0, 0, 0, 1023));
    pending_items.push_back(shaped(MODE_PATTERN, 0, 0, 0, 0));
    pending_items.push_back(shaped(MODE_PATTERN, 0, 0, 0, 10'h2AA));
    pending_items.push_back(shaped(MODE_SPARE_LO, 0, 0, 0, 0));
    pending_items.push_back(shaped(MODE_SPARE_HI, 80, 15, 15, 1023));
    wait_idle();

    random_phase(1'b1, 16'hFFFF, 100, IDLE_PERCENT);
    // Long stretch with start offered every cycle
    random_phase(1'b0, 16'h0000, 100, 0);
    random_phase(1'b1, 16'($urandom_range(65535)), 100, IDLE_PERCENT);

    $display("Ran %0d commands over all modes and both segment orders, checked %0d words,",
             items_accepted, words_checked);
    $display("with %0d mismatches.", mismatch_count);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
